// ===== design/euler_angles_to_rotation_matrix_defines.svh =====
// Assertion macros shared by the euler_angles_to_rotation_matrix design.
// Included by the top level; the bodies compile away under SYNTHESIS.
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_DEFINES_SVH
`ifndef SYNTHESIS
`define EATRM_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("eatrm: implication check failed");
`define EATRM_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("eatrm: next-cycle check failed");
`else
`define EATRM_ASSERT_IMP(label, clk, rst, a, b)
`define EATRM_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== design/eatrm_pkg.sv =====
// Package for euler_angles_to_rotation_matrix: word types, fixed-point constants, latencies.
// No dependencies.
package eatrm_pkg;

  localparam int ANGLE_FRAC_BITS = 8;
  localparam int OUT_FRAC_BITS   = 14;
  localparam int ANGLE_W         = 24;
  localparam int ENTRY_W         = 16;
  localparam int Q30_W           = 32;
  localparam int SERIES_TERMS    = 7;
  localparam int NTERM           = SERIES_TERMS - 1;

  localparam longint FULL_TURN   = longint'(360) << ANGLE_FRAC_BITS;
  localparam longint QUARTER     = longint'(90) << ANGLE_FRAC_BITS;
  localparam longint EIGHTH      = longint'(45) << ANGLE_FRAC_BITS;
  localparam longint HALF_DIV    = longint'(180) << ANGLE_FRAC_BITS;
  localparam longint TURN_OFFSET =
    FULL_TURN * (((longint'(1) << (ANGLE_W - 1)) / FULL_TURN) + 1);
  localparam longint RECIP_FULL  = (longint'(1) << 32) / FULL_TURN;
  localparam longint PI_Q32      = 64'd13493037705;
  localparam longint PI_HI       = PI_Q32 / HALF_DIV;
  localparam longint PI_LO       = PI_Q32 - PI_HI * HALF_DIV;
  localparam longint RECIP_HALF  = (longint'(1) << 32) / HALF_DIV;

  localparam logic [31:0] SIN_DIV [NTERM] = '{32'd6, 32'd20, 32'd42, 32'd72, 32'd110, 32'd156};
  localparam logic [31:0] COS_DIV [NTERM] = '{32'd2, 32'd12, 32'd30, 32'd56, 32'd90, 32'd132};
  localparam logic [31:0] SIN_RCP [NTERM] = '{
    32'((64'd1 << 32) / 64'd6),   32'((64'd1 << 32) / 64'd20),
    32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd72),
    32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd156)};
  localparam logic [31:0] COS_RCP [NTERM] = '{
    32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 32) / 64'd12),
    32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd56),
    32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd132)};

  localparam int FINISH_SHIFT = 30 - OUT_FRAC_BITS;
  localparam int ONE_OUT      = 1 << OUT_FRAC_BITS;

  localparam int FRONT_LAT  = 7;
  localparam int LANE_LAT   = FRONT_LAT + 3 * NTERM + 1;
  localparam int MATRIX_LAT = 4;
  localparam int TOTAL_LAT  = LANE_LAT + MATRIX_LAT;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_x;
    logic signed [ANGLE_W-1:0] angle_y;
    logic signed [ANGLE_W-1:0] angle_z;
  } in_t;

  typedef struct packed {
    logic signed [ENTRY_W-1:0] entry_0;
    logic signed [ENTRY_W-1:0] entry_1;
    logic signed [ENTRY_W-1:0] entry_2;
    logic signed [ENTRY_W-1:0] entry_3;
    logic signed [ENTRY_W-1:0] entry_4;
    logic signed [ENTRY_W-1:0] entry_5;
    logic signed [ENTRY_W-1:0] entry_6;
    logic signed [ENTRY_W-1:0] entry_7;
    logic signed [ENTRY_W-1:0] entry_8;
  } out_t;

  typedef struct packed {
    logic signed [Q30_W-1:0] sn;
    logic signed [Q30_W-1:0] cs;
  } trig_t;

endpackage

// ===== design/eatrm_lane.sv =====
// One sine/cosine lane: negate, reduce mod 360, fold, convert to radians, series.
// Depends on eatrm_pkg.
module eatrm_lane (
  input  logic                                   clk,
  input  logic signed [eatrm_pkg::ANGLE_W-1:0]   angle,
  output eatrm_pkg::trig_t                       trig
);

  localparam int NT   = eatrm_pkg::NTERM;
  localparam int FLEN = eatrm_pkg::LANE_LAT - 3;

  logic [24:0] turn_c;
  logic [24:0] n1;
  logic [8:0]  q1;
  logic [40:0] q1_prod;
  logic [24:0] r0_c;
  logic [16:0] r2;
  logic [1:0]  quad_c;
  logic [16:0] u_c;
  logic        swap_c;
  logic [13:0] v3;
  logic [31:0] ha4, ha5;
  logic [28:0] nb4, nb5;
  logic [45:0] qb_prod;
  logic [13:0] qb5;
  logic [28:0] rb_c;
  logic [31:0] x6;
  logic [63:0] xx_prod;
  logic [31:0] x2_q [NT+1];
  logic [31:0] ts_q [NT+1];
  logic [32:0] tc_q [NT+1];
  logic [33:0] ss_q [NT+1];
  logic [33:0] sc_q [NT+1];
  logic [2:0]  fold_d [FLEN];
  logic [31:0] s0_c, c0_c, fs_c, fc_c;

  always_comb begin
    turn_c  = 25'(eatrm_pkg::TURN_OFFSET) - {angle[eatrm_pkg::ANGLE_W-1], angle};
    q1_prod = 41'(turn_c) * 41'(eatrm_pkg::RECIP_FULL);
  end

  always_ff @(posedge clk) begin
    n1 <= turn_c;
    q1 <= q1_prod[40:32];
  end

  always_comb begin
    r0_c = n1 - 25'(q1 * 25'(eatrm_pkg::FULL_TURN));
  end

  always_ff @(posedge clk) begin
    if (r0_c >= 25'(eatrm_pkg::FULL_TURN)) begin
      r2 <= 17'(r0_c - 25'(eatrm_pkg::FULL_TURN));
    end else begin
      r2 <= 17'(r0_c);
    end
  end

  always_comb begin
    if (r2 < 17'(eatrm_pkg::QUARTER)) begin
      quad_c = 2'd0;
    end else if (r2 < 17'(2 * eatrm_pkg::QUARTER)) begin
      quad_c = 2'd1;
    end else if (r2 < 17'(3 * eatrm_pkg::QUARTER)) begin
      quad_c = 2'd2;
    end else begin
      quad_c = 2'd3;
    end
    u_c    = r2 - 17'(quad_c) * 17'(eatrm_pkg::QUARTER);
    swap_c = (u_c > 17'(eatrm_pkg::EIGHTH));
  end

  always_ff @(posedge clk) begin
    v3        <= swap_c ? 14'(17'(eatrm_pkg::QUARTER) - u_c) : 14'(u_c);
    fold_d[0] <= {quad_c, swap_c};
  end

  for (genvar i = 1; i < FLEN; i++) begin : g_fold
    always_ff @(posedge clk) begin
      fold_d[i] <= fold_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    ha4 <= 32'(v3) * 32'(eatrm_pkg::PI_HI);
    nb4 <= 29'(v3) * 29'(eatrm_pkg::PI_LO) + 29'(eatrm_pkg::HALF_DIV / 2);
  end

  always_comb begin
    qb_prod = 46'(nb4) * 46'(eatrm_pkg::RECIP_HALF);
  end

  always_ff @(posedge clk) begin
    qb5 <= qb_prod[45:32];
    ha5 <= ha4;
    nb5 <= nb4;
  end

  always_comb begin
    rb_c = nb5 - 29'(qb5) * 29'(eatrm_pkg::HALF_DIV);
  end

  always_ff @(posedge clk) begin
    x6 <= ha5 + 32'(qb5) + 32'(rb_c >= 29'(eatrm_pkg::HALF_DIV));
  end

  always_comb begin
    xx_prod = 64'(x6) * 64'(x6);
  end

  always_ff @(posedge clk) begin
    x2_q[0] <= xx_prod[63:32];
    ts_q[0] <= x6;
    tc_q[0] <= 33'h1_0000_0000;
    ss_q[0] <= 34'(x6);
    sc_q[0] <= 34'h1_0000_0000;
  end

  for (genvar k = 0; k < NT; k++) begin : g_term
    logic [64:0] ps_prod, pc_prod;
    logic [31:0] ps1, pc1, ps2, pc2, qs2, qc2, x2a, x2b;
    logic [33:0] ssa, sca, ssb, scb;
    logic [63:0] qs_prod, qc_prod;
    logic [32:0] rs_c, rc_c;
    logic [31:0] ts_c, tc_c;

    always_comb begin
      ps_prod = 65'(ts_q[k]) * 65'(x2_q[k]);
      pc_prod = 65'(tc_q[k]) * 65'(x2_q[k]);
    end

    always_ff @(posedge clk) begin
      ps1 <= ps_prod[63:32];
      pc1 <= pc_prod[63:32];
      x2a <= x2_q[k];
      ssa <= ss_q[k];
      sca <= sc_q[k];
    end

    always_comb begin
      qs_prod = 64'(ps1) * 64'(eatrm_pkg::SIN_RCP[k]);
      qc_prod = 64'(pc1) * 64'(eatrm_pkg::COS_RCP[k]);
    end

    always_ff @(posedge clk) begin
      qs2 <= qs_prod[63:32];
      qc2 <= qc_prod[63:32];
      ps2 <= ps1;
      pc2 <= pc1;
      x2b <= x2a;
      ssb <= ssa;
      scb <= sca;
    end

    always_comb begin
      rs_c = 33'(ps2) - 33'(qs2) * 33'(eatrm_pkg::SIN_DIV[k]);
      rc_c = 33'(pc2) - 33'(qc2) * 33'(eatrm_pkg::COS_DIV[k]);
      ts_c = qs2 + 32'(rs_c >= 33'(eatrm_pkg::SIN_DIV[k]));
      tc_c = qc2 + 32'(rc_c >= 33'(eatrm_pkg::COS_DIV[k]));
    end

    always_ff @(posedge clk) begin
      x2_q[k+1] <= x2b;
      ts_q[k+1] <= ts_c;
      tc_q[k+1] <= 33'(tc_c);
      if ((k % 2) == 0) begin
        ss_q[k+1] <= ssb - 34'(ts_c);
        sc_q[k+1] <= scb - 34'(tc_c);
      end else begin
        ss_q[k+1] <= ssb + 34'(ts_c);
        sc_q[k+1] <= scb + 34'(tc_c);
      end
    end
  end

  always_comb begin
    s0_c = 32'((ss_q[NT] + 34'd2) >> 2);
    c0_c = 32'((sc_q[NT] + 34'd2) >> 2);
    fs_c = fold_d[FLEN-1][0] ? c0_c : s0_c;
    fc_c = fold_d[FLEN-1][0] ? s0_c : c0_c;
  end

  always_ff @(posedge clk) begin
    case (fold_d[FLEN-1][2:1])
      2'd0: begin
        trig.sn <= fs_c;
        trig.cs <= fc_c;
      end
      2'd1: begin
        trig.sn <= fc_c;
        trig.cs <= -fs_c;
      end
      2'd2: begin
        trig.sn <= -fs_c;
        trig.cs <= -fc_c;
      end
      default: begin
        trig.sn <= -fc_c;
        trig.cs <= fs_c;
      end
    endcase
  end

endmodule

// ===== design/eatrm_matrix.sv =====
// Merge stage: forms the nine rotation matrix entries from the three lanes.
// Depends on eatrm_pkg.
module eatrm_matrix (
  input  logic             clk,
  input  eatrm_pkg::trig_t tx,
  input  eatrm_pkg::trig_t ty,
  input  eatrm_pkg::trig_t tz,
  output eatrm_pkg::out_t  matrix
);

  typedef logic signed [31:0] q30_t;
  typedef logic signed [32:0] sum_t;

  function automatic q30_t mul30(input q30_t a, input q30_t b);
    logic [30:0] ma, mb;
    logic [61:0] p;
    logic [31:0] r;
    ma = a[31] ? 31'(-a) : 31'(a);
    mb = b[31] ? 31'(-b) : 31'(b);
    p  = 62'(ma) * 62'(mb);
    r  = 32'((p + 62'(1) * (62'd1 << 29)) >> 30);
    return (a[31] ^ b[31]) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [15:0] finish(input sum_t v);
    logic [32:0] mag;
    logic [32:0] r;
    logic [32:0] clipped;
    mag = v[32] ? 33'(-v) : 33'(v);
    r   = (mag + (33'd1 << (eatrm_pkg::FINISH_SHIFT - 1))) >> eatrm_pkg::FINISH_SHIFT;
    clipped = (r > 33'(eatrm_pkg::ONE_OUT)) ? 33'(eatrm_pkg::ONE_OUT) : r;
    return v[32] ? -$signed(16'(clipped)) : $signed(16'(clipped));
  endfunction

  q30_t cycz, sysx, cysz, sycx, czcx, czsx, sycz, sysz, cysx, cycx, sx1, cx1, sz1;
  q30_t cycz2, sysx2, sycx2, czcx2, czsx2, sycz2, cysx2, cycx2, sz2;
  q30_t cyszcx, cyszsx, syszcx, syszsx;
  sum_t e0, e1, e2, e3, e4, e5, e6, e7, e8;

  always_ff @(posedge clk) begin
    cycz <= mul30(ty.cs, tz.cs);
    sysx <= mul30(ty.sn, tx.sn);
    cysz <= mul30(ty.cs, tz.sn);
    sycx <= mul30(ty.sn, tx.cs);
    czcx <= mul30(tz.cs, tx.cs);
    czsx <= mul30(tz.cs, tx.sn);
    sycz <= mul30(ty.sn, tz.cs);
    sysz <= mul30(ty.sn, tz.sn);
    cysx <= mul30(ty.cs, tx.sn);
    cycx <= mul30(ty.cs, tx.cs);
    sx1  <= tx.sn;
    cx1  <= tx.cs;
    sz1  <= tz.sn;
  end

  always_ff @(posedge clk) begin
    cyszcx <= mul30(cysz, cx1);
    cyszsx <= mul30(cysz, sx1);
    syszcx <= mul30(sysz, cx1);
    syszsx <= mul30(sysz, sx1);
    cycz2  <= cycz;
    sysx2  <= sysx;
    sycx2  <= sycx;
    czcx2  <= czcx;
    czsx2  <= czsx;
    sycz2  <= sycz;
    cysx2  <= cysx;
    cycx2  <= cycx;
    sz2    <= sz1;
  end

  always_ff @(posedge clk) begin
    e0 <= 33'(cycz2);
    e1 <= 33'(sysx2) - 33'(cyszcx);
    e2 <= 33'(cyszsx) + 33'(sycx2);
    e3 <= 33'(sz2);
    e4 <= 33'(czcx2);
    e5 <= -33'(czsx2);
    e6 <= -33'(sycz2);
    e7 <= 33'(syszcx) + 33'(cysx2);
    e8 <= 33'(cycx2) - 33'(syszsx);
  end

  always_ff @(posedge clk) begin
    matrix.entry_0 <= finish(e0);
    matrix.entry_1 <= finish(e1);
    matrix.entry_2 <= finish(e2);
    matrix.entry_3 <= finish(e3);
    matrix.entry_4 <= finish(e4);
    matrix.entry_5 <= finish(e5);
    matrix.entry_6 <= finish(e6);
    matrix.entry_7 <= finish(e7);
    matrix.entry_8 <= finish(e8);
  end

endmodule

// ===== design/euler_angles_to_rotation_matrix.sv =====
// Top level: three sine/cosine lanes, matrix merge stage, valid tracking.
// Depends on eatrm_pkg, eatrm_lane, eatrm_matrix and the defines header.
//
// Takes one word of three Euler angles per clock (busy is high only in reset)
// and returns the 3x3 rotation matrix for each word on the matrix output with
// done high for that one cycle. The latency is set by the 26-stage sine/cosine
// lane (angle reduction, radian conversion and six pipelined series terms of
// three stages each) followed by the four-stage product and rounding pipeline.
// No reset clearing pass; results cannot be held off.
`include "euler_angles_to_rotation_matrix_defines.svh"
module euler_angles_to_rotation_matrix (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  eatrm_pkg::in_t  angles,
  output logic            busy,
  output logic            done,
  output eatrm_pkg::out_t matrix
);

  localparam int LAT = eatrm_pkg::TOTAL_LAT;

  logic [LAT-1:0]   valid;
  eatrm_pkg::trig_t tx, ty, tz;

  assign busy = rst;
  assign done = valid[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[LAT-2:0], start && !busy};
    end
  end

  eatrm_lane u_lane_x (.clk(clk), .angle(angles.angle_x), .trig(tx));
  eatrm_lane u_lane_y (.clk(clk), .angle(angles.angle_y), .trig(ty));
  eatrm_lane u_lane_z (.clk(clk), .angle(angles.angle_z), .trig(tz));

  eatrm_matrix u_matrix (.clk(clk), .tx(tx), .ty(ty), .tz(tz), .matrix(matrix));

  `EATRM_ASSERT_NEXT(a_accept_tracked, clk, rst, start && !busy, valid[0])
  `EATRM_ASSERT_IMP(a_done_has_source, clk, rst, done, $past(start && !busy, LAT))
  `EATRM_ASSERT_IMP(a_entry_clipped, clk, rst, done, ($signed(matrix.entry_0) <= 16'sd16384) && ($signed(matrix.entry_0) >= -16'sd16384) && ($signed(matrix.entry_8) <= 16'sd16384) && ($signed(matrix.entry_8) >= -16'sd16384))

endmodule

// ===== sim/tb_euler_angles_to_rotation_matrix.sv =====
// Testbench for euler_angles_to_rotation_matrix: directed table, then random angle words,
// each result checked field by field against a fixed-point rotation matrix predictor
// (the all-zero first word against a typed-in identity). Depends on eatrm_pkg and the design files.
module tb_euler_angles_to_rotation_matrix;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_DIRECTED = 20;
  localparam int N_RANDOM   = 400;
  localparam longint PI_Q32_TB = 64'd13493037705;

  logic clk, rst, start, busy, done;
  eatrm_pkg::in_t  angles;
  eatrm_pkg::out_t matrix;

  eatrm_pkg::out_t matrix_q[$];
  int   errors, n_checked, n_sent;
  int   idle_pct;

  euler_angles_to_rotation_matrix dut (
    .clk(clk), .rst(rst), .start(start), .angles(angles),
    .busy(busy), .done(done), .matrix(matrix)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint rnd_away(longint v, int sh);
    longint mag, r;
    mag = (v < 0) ? -v : v;
    r = (sh == 0) ? mag : ((mag + (longint'(1) << (sh - 1))) >>> sh);
    return (v < 0) ? -r : r;
  endfunction

  function automatic void taylor_sincos(longint unsigned x, output longint unsigned s,
                                        output longint unsigned c);
    longint unsigned x2, ts, tc;
    x2 = (x * x) >> 32;
    ts = x; s = x;
    tc = 64'd1 << 32; c = tc;
    for (int k = 1; k < 7; k++) begin
      ts = ((ts * x2) >> 32) / longint'((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >> 32) / longint'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        s -= ts; c -= tc;
      end else begin
        s += ts; c += tc;
      end
    end
  endfunction

  function automatic void neg_angle_trig(logic signed [23:0] a, output longint sn,
                                         output longint cs);
    longint full, quarter, eighth, r, q, u, v, s0, c0, fs, fc;
    longint unsigned x, ss, cc;
    full = longint'(360) << 8;
    quarter = longint'(90) << 8;
    eighth = longint'(45) << 8;
    r = (-longint'(a)) % full;
    if (r < 0) r += full;
    q = r / quarter;
    u = r - q * quarter;
    v = (u > eighth) ? quarter - u : u;
    x = (longint'(v) * PI_Q32_TB + ((longint'(180) << 8) >> 1)) / (longint'(180) << 8);
    taylor_sincos(x, ss, cc);
    s0 = rnd_away(longint'(ss), 2);
    c0 = rnd_away(longint'(cc), 2);
    if (u > eighth) begin
      fs = c0; fc = s0;
    end else begin
      fs = s0; fc = c0;
    end
    case (q & 3)
      0: begin sn = fs;  cs = fc;  end
      1: begin sn = fc;  cs = -fs; end
      2: begin sn = -fs; cs = -fc; end
      default: begin sn = -fc; cs = fs; end
    endcase
  endfunction

  function automatic longint m30(longint a, longint b);
    return rnd_away(a * b, 30);
  endfunction

  function automatic logic [15:0] to_entry(longint v);
    longint one, r;
    one = longint'(1) << eatrm_pkg::OUT_FRAC_BITS;
    r = rnd_away(v, 30 - eatrm_pkg::OUT_FRAC_BITS);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[15:0];
  endfunction

  function automatic eatrm_pkg::out_t rotation_matrix(eatrm_pkg::in_t w);
    longint sx, cx, sy, cy, sz, cz;
    eatrm_pkg::out_t m;
    neg_angle_trig(w.angle_x, sx, cx);
    neg_angle_trig(w.angle_y, sy, cy);
    neg_angle_trig(w.angle_z, sz, cz);
    m.entry_0 = to_entry(m30(cy, cz));
    m.entry_1 = to_entry(m30(sy, sx) - m30(m30(cy, sz), cx));
    m.entry_2 = to_entry(m30(m30(cy, sz), sx) + m30(sy, cx));
    m.entry_3 = to_entry(sz);
    m.entry_4 = to_entry(m30(cz, cx));
    m.entry_5 = to_entry(-m30(cz, sx));
    m.entry_6 = to_entry(-m30(sy, cz));
    m.entry_7 = to_entry(m30(m30(sy, sz), cx) + m30(cy, sx));
    m.entry_8 = to_entry(m30(cy, cx) - m30(m30(sy, sz), sx));
    return m;
  endfunction

  // identity row typed in; the rest go through the predictor
  function automatic eatrm_pkg::in_t directed_word(int i);
    eatrm_pkg::in_t w;
    logic signed [23:0] d90;
    d90 = 24'sd23040;
    case (i)
      0:  w = '{24'sd0, 24'sd0, 24'sd0};
      1:  w = '{d90, 24'sd0, 24'sd0};
      2:  w = '{24'sd0, d90, 24'sd0};
      3:  w = '{24'sd0, 24'sd0, d90};
      4:  w = '{-d90, -d90, -d90};
      5:  w = '{24'(2 * d90), 24'(3 * d90), 24'(4 * d90)};
      6:  w = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
      7:  w = '{24'sh800000, 24'sh800000, 24'sh800000};
      8:  w = '{24'sh7FFFFF, 24'sh800000, 24'sh000001};
      9:  w = '{24'shFFFFFF, 24'sh000001, 24'shFFFFFF};
      10: w = '{24'sd11520, 24'sd11520, 24'sd11520};
      11: w = '{24'sd11521, 24'sd11519, -24'sd11520};
      12: w = '{24'sd34560, 24'sd57600, 24'sd80640};
      13: w = '{24'sd92160, -24'sd92160, 24'sd184320};
      14: w = '{24'sd7680, 24'sd15360, 24'sd3840};
      15: w = '{24'sh555555, 24'shAAAAAA, 24'sh123456};
      16: w = '{24'shAAAAAA, 24'sh555555, 24'shEDCBA9};
      17: w = '{24'sd23039, 24'sd23041, 24'sd46079};
      18: w = '{24'sd1, 24'sd255, 24'sd256};
      default: w = '{-24'sd1, -24'sd256, 24'sd92159};
    endcase
    return w;
  endfunction

  function automatic logic signed [23:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'(23040 * $signed($urandom_range(0, 16)) - 23040 * 8);
      2: return 24'($signed($urandom_range(0, 184320)) - 92160);
      default: return 24'(11520 * $signed($urandom_range(0, 64)) - 368640
                          + $signed($urandom_range(0, 2)) - 1);
    endcase
  endfunction

  task automatic send_word(eatrm_pkg::in_t w, bit typed, eatrm_pkg::out_t exp_m);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    angles <= w;
    matrix_q.push_back(typed ? exp_m : rotation_matrix(w));
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (matrix_q.size() == 0) begin
        $display("%0t: unexpected matrix %h", $time, matrix);
        errors++;
      end else begin
        eatrm_pkg::out_t e;
        e = matrix_q.pop_front();
        n_checked++;
        for (int k = 0; k < 9; k++) begin
          if (e[16 * k +: 16] !== matrix[16 * k +: 16]) begin
            $display("%0t: entry_%0d expected %h actual %h", $time, 8 - k,
                     e[16 * k +: 16], matrix[16 * k +: 16]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    eatrm_pkg::out_t ident;
    int waited;
    errors = 0; n_checked = 0; n_sent = 0; idle_pct = 0;
    ident = '0;
    ident.entry_0 = 16'(eatrm_pkg::ONE_OUT);
    ident.entry_4 = 16'(eatrm_pkg::ONE_OUT);
    ident.entry_8 = 16'(eatrm_pkg::ONE_OUT);
    rst = 1'b1; start = 1'b0; angles = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    for (int i = 0; i < N_DIRECTED; i++)
      send_word(directed_word(i), i == 0, ident);
    start <= 1'b0;
    // hold until the pipeline drains
    while (matrix_q.size() != 0) @(negedge clk);
    for (int i = 0; i < N_RANDOM; i++) begin
      idle_pct = (i < N_RANDOM / 3) ? 36 : (i < 2 * N_RANDOM / 3) ? 81 : 0;
      send_word('{rand_angle(), rand_angle(), rand_angle()}, 1'b0, ident);
    end
    start <= 1'b0;
    waited = 0;
    while (matrix_q.size() != 0 && waited < 1000) begin
      @(negedge clk);
      waited++;
    end
    repeat (eatrm_pkg::TOTAL_LAT + 10) @(negedge clk);
    if (matrix_q.size() != 0) begin
      $display("%0t: %0d matrices never arrived", $time, matrix_q.size());
      errors++;
    end
    $display("Covered %0d angle words (quadrant edges, octant folds, full range), %0d checked",
             n_sent, n_checked);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
